// ===== rtl/core/lhfm_pkg.sv =====
// Link health / failover monitor: shared types, codes and the status judge.
// No dependencies; used by the top level and by its checker.
`default_nettype none

package lhfm_pkg;

  // action codes
  localparam logic [1:0] ACT_CFG  = 2'd0;
  localparam logic [1:0] ACT_UPD  = 2'd1;
  localparam logic [1:0] ACT_FAIL = 2'd2;

  // link status codes
  localparam logic [1:0] ST_HEALTHY  = 2'd0;
  localparam logic [1:0] ST_DEGRADED = 2'd1;
  localparam logic [1:0] ST_LOST     = 2'd2;

  // result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_EVENT  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_LOSS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_RSSI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEG_LOSS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEG_RSSI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEG_LAT   = 3'd4;

  // event cap per failover request
  localparam int MAX_RESULTS = 8;
  localparam int RES_CNT_W   = 4;

  // metric values a slot holds after reset or configure
  localparam logic signed [11:0] RST_RSSI = -12'sd700;
  localparam logic [9:0]         RST_LOSS = 10'd0;
  localparam logic [15:0]        RST_LAT  = 16'd20;

  typedef struct packed {
    logic [1:0]         action;
    logic [2:0]         slot_index;
    logic [1:0]         link_class;
    logic [7:0]         link_priority;
    logic               start_active;
    logic signed [11:0] rssi_tenths;
    logic [9:0]         loss_tenths;
    logic [15:0]        latency_ms;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [2:0] link_slot;
    logic [1:0] link_status;
    logic       backup_found;
    logic [2:0] backup_slot;
    logic       last_result;
  } out_item_t;

  typedef struct packed {
    logic [9:0]         lost_loss;
    logic signed [11:0] lost_rssi;
    logic [9:0]         deg_loss;
    logic signed [11:0] deg_rssi;
    logic [15:0]        deg_lat;
  } limits_t;

  function automatic logic [1:0] judge(input logic [11:0] rssi, input logic [9:0] loss,
                                       input logic [15:0] lat, input limits_t lim);
    logic [1:0] st;
    if (loss > lim.lost_loss || $signed(rssi) < $signed(lim.lost_rssi)) begin
      st = ST_LOST;
    end else if (loss > lim.deg_loss || $signed(rssi) < $signed(lim.deg_rssi) ||
                 lat > lim.deg_lat) begin
      st = ST_DEGRADED;
    end else begin
      st = ST_HEALTHY;
    end
    return st;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/link_health_failover_monitor.sv =====
// Link health / failover monitor top level: slot table, scan sequencer, result register.
// Depends on lhfm_pkg and lhfm_ram.
`default_nettype none

// Usage
//   Input channel (in_valid / in_stall / in_data) takes one request at a time:
//   configure a slot, update its metrics, or run a failover scan.
//   Output channel (out_valid / out_stall / out_data) gives result items
//   from a single output register; last_result marks the final one of a
//   request. A request that yields nothing (scan with no failed slot,
//   unused action) gives no result.
//   Config port (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   five limit registers; cfg_ready is always high, write only when idle.
// Sequence
//   configure: the slot word is written at accept and the report goes
//   out from S_PUSH; update: read, modify, write of the slot word in
//   S_UPD, then S_PUSH. failover: slots are checked one at a time, and each
//   failed slot costs a full pass over the table to find its backup, as
//   the table RAM has one read port. The next request is taken once the
//   block is back in S_IDLE.
// Reset clears per-slot valid bits, so there is no clearing pass; an
// unwritten slot reads as its reset contents. A stalled receiver holds the
// output register and the sequencer waits before loading the next result.

module link_health_failover_monitor #(
  parameter int NUM_SLOTS     = 8,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lhfm_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output lhfm_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lhfm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lhfm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);

  // one table word per slot
  typedef struct packed {
    logic                     present;
    logic [1:0]               cls;
    logic [PRIORITY_BITS-1:0] prio;
    logic                     active;
    logic signed [11:0]       rssi;
    logic [9:0]               loss;
    logic [15:0]              lat;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  localparam rec_t RESET_REC = '{
    present: 1'b0,
    cls:     2'd0,
    prio:    PRIORITY_BITS'(1),
    active:  1'b0,
    rssi:    lhfm_pkg::RST_RSSI,
    loss:    lhfm_pkg::RST_LOSS,
    lat:     lhfm_pkg::RST_LAT
  };

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_UPD   = 8'b0000_0010,
    S_PUSH  = 8'b0000_0100,
    S_CHK   = 8'b0000_1000,
    S_INNER = 8'b0001_0000,
    S_ACT   = 8'b0010_0000,
    S_EVENT = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state;

  lhfm_pkg::limits_t   lim;
  lhfm_pkg::in_item_t  item;
  lhfm_pkg::out_item_t res;      // report to send, or pending scan event
  lhfm_pkg::out_item_t ev;
  lhfm_pkg::out_item_t out_word;
  logic                have_pend;

  logic [AW-1:0]                    scan_s;
  logic [lhfm_pkg::RES_CNT_W-1:0]   n_res;
  logic [CW-1:0]                    issue_cnt;
  logic [1:0]                       failed_cls;
  logic                             found;
  logic [AW-1:0]                    best_idx;
  rec_t                             best_rec;

  logic [NUM_SLOTS-1:0] valid_bits;
  logic [AW-1:0]        rd_addr_q;
  logic                 rd_valid_q;

  // RAM ports
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [REC_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [REC_W-1:0] ram_rdata;

  rec_t       rd_rec;
  rec_t       cfg_rec;
  rec_t       upd_rec;
  rec_t       off_rec;
  rec_t       on_rec;
  logic [1:0] rd_st;

  logic          in_acc;
  logic          in_inr;
  logic          item_inr;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] item_addr;
  logic          scan_last;
  logic          inner_last;
  logic          issue_more;
  logic          rd_fail;
  logic          cand_better;
  logic          out_free;
  logic          out_load;

  lhfm_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // output register takes a report, or the held-back event once a newer one exists or the scan ends
  assign out_load  = out_free && ((state == S_PUSH) ||
                                  (have_pend && (state == S_EVENT || state == S_FIN)));

  assign in_inr    = (32'(in_data.slot_index) < NUM_SLOTS);
  assign item_inr  = (32'(item.slot_index) < NUM_SLOTS);
  assign in_addr   = AW'(in_data.slot_index);
  assign item_addr = AW'(item.slot_index);

  assign scan_last  = (scan_s == AW'(NUM_SLOTS - 1));
  assign inner_last = (rd_addr_q == AW'(NUM_SLOTS - 1));
  assign issue_more = (issue_cnt < CW'(NUM_SLOTS));

  // never-written slots read as their reset contents
  assign rd_rec = rd_valid_q ? rec_t'(ram_rdata) : RESET_REC;
  assign rd_st  = lhfm_pkg::judge(rd_rec.rssi, rd_rec.loss, rd_rec.lat, lim);

  assign rd_fail     = rd_rec.present && rd_rec.active && (rd_st == lhfm_pkg::ST_LOST);
  assign cand_better = rd_rec.present && (rd_rec.cls == failed_cls) &&
                       (rd_st != lhfm_pkg::ST_LOST) &&
                       (!found || (rd_rec.prio > best_rec.prio));

  // final event of a scan carries last_result
  always_comb begin
    out_word = res;
    if (state == S_FIN) begin
      out_word.last_result = 1'b1;
    end
  end

  // candidate write words
  always_comb begin
    cfg_rec         = RESET_REC;
    cfg_rec.present = 1'b1;
    cfg_rec.cls     = in_data.link_class;
    cfg_rec.prio    = PRIORITY_BITS'(in_data.link_priority);
    cfg_rec.active  = in_data.start_active;

    upd_rec      = rd_rec;
    upd_rec.rssi = item.rssi_tenths;
    upd_rec.loss = item.loss_tenths;
    upd_rec.lat  = item.latency_ms;

    off_rec        = rd_rec;
    off_rec.active = 1'b0;

    on_rec        = best_rec;
    on_rec.active = 1'b1;
  end

  // table port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      S_IDLE: begin
        if (in_acc && in_data.action == lhfm_pkg::ACT_CFG && in_inr) begin
          ram_we    = 1'b1;
          ram_waddr = in_addr;
          ram_wdata = REC_W'(cfg_rec);
        end
        if (in_acc && in_data.action == lhfm_pkg::ACT_UPD) begin
          ram_raddr = in_addr;
        end
      end
      S_UPD: begin
        if (item_inr) begin
          ram_we    = 1'b1;
          ram_waddr = item_addr;
          ram_wdata = REC_W'(upd_rec);
        end
      end
      S_CHK: begin
        if (rd_fail) begin
          // deactivate the failed slot, start the backup search at slot 0
          ram_we    = 1'b1;
          ram_waddr = scan_s;
          ram_wdata = REC_W'(off_rec);
        end else if (!scan_last) begin
          ram_raddr = scan_s + AW'(1);
        end
      end
      S_INNER: begin
        if (issue_more) begin
          ram_raddr = AW'(issue_cnt);
        end
      end
      S_ACT: begin
        if (found) begin
          ram_we    = 1'b1;
          ram_waddr = best_idx;
          ram_wdata = REC_W'(on_rec);
        end
      end
      S_EVENT: begin
        // reissued each cycle while waiting; harmless
        if (!scan_last) begin
          ram_raddr = scan_s + AW'(1);
        end
      end
      S_PUSH, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lim.lost_loss <= 10'd500;
      lim.lost_rssi <= -12'sd900;
      lim.deg_loss  <= 10'd100;
      lim.deg_rssi  <= -12'sd800;
      lim.deg_lat   <= 16'd200;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lhfm_pkg::REG_LOST_LOSS: lim.lost_loss <= cfg_data[9:0];
        lhfm_pkg::REG_LOST_RSSI: lim.lost_rssi <= cfg_data[11:0];
        lhfm_pkg::REG_DEG_LOSS:  lim.deg_loss  <= cfg_data[9:0];
        lhfm_pkg::REG_DEG_RSSI:  lim.deg_rssi  <= cfg_data[11:0];
        lhfm_pkg::REG_DEG_LAT:   lim.deg_lat   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // read tracking: valid bit sampled with the read so a same-cycle write
  // does not change what the data word means
  always_ff @(posedge clk) begin
    rd_addr_q  <= ram_raddr;
    rd_valid_q <= valid_bits[ram_raddr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_data <= out_word;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      have_pend  <= 1'b0;
      found      <= 1'b0;
      n_res      <= '0;
    end else begin
      if (ram_we) begin
        valid_bits[ram_waddr] <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            item <= in_data;
            unique case (in_data.action)
              lhfm_pkg::ACT_CFG: begin
                res.result_kind  <= lhfm_pkg::KIND_REPORT;
                res.link_slot    <= in_data.slot_index;
                res.link_status  <= lhfm_pkg::judge(lhfm_pkg::RST_RSSI, lhfm_pkg::RST_LOSS,
                                                     lhfm_pkg::RST_LAT, lim);
                res.backup_found <= 1'b0;
                res.backup_slot  <= 3'd0;
                res.last_result  <= 1'b1;
                state            <= S_PUSH;
              end
              lhfm_pkg::ACT_UPD: begin
                state <= S_UPD;
              end
              lhfm_pkg::ACT_FAIL: begin
                scan_s    <= '0;
                n_res     <= '0;
                have_pend <= 1'b0;
                state     <= S_CHK;
              end
              default: begin
              end
            endcase
          end
        end

        S_UPD: begin
          res.result_kind  <= lhfm_pkg::KIND_REPORT;
          res.link_slot    <= item.slot_index;
          res.link_status  <= lhfm_pkg::judge(item.rssi_tenths, item.loss_tenths,
                                               item.latency_ms, lim);
          res.backup_found <= 1'b0;
          res.backup_slot  <= 3'd0;
          res.last_result  <= 1'b1;
          state            <= S_PUSH;
        end

        S_PUSH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        S_CHK: begin
          if (rd_fail) begin
            failed_cls <= rd_rec.cls;
            found      <= 1'b0;
            issue_cnt  <= CW'(1);
            state      <= S_INNER;
          end else if (scan_last) begin
            state <= S_FIN;
          end else begin
            scan_s <= scan_s + AW'(1);
          end
        end

        S_INNER: begin
          if (issue_more) begin
            issue_cnt <= issue_cnt + CW'(1);
          end
          // strict compare keeps the lowest index on ties
          if (cand_better) begin
            found    <= 1'b1;
            best_idx <= rd_addr_q;
            best_rec <= rd_rec;
          end
          if (inner_last) begin
            state <= S_ACT;
          end
        end

        S_ACT: begin
          ev.result_kind  <= lhfm_pkg::KIND_EVENT;
          ev.link_slot    <= 3'(scan_s);
          ev.link_status  <= lhfm_pkg::ST_LOST;
          ev.backup_found <= found;
          ev.backup_slot  <= found ? 3'(best_idx) : 3'd0;
          ev.last_result  <= 1'b0;
          state           <= S_EVENT;
        end

        S_EVENT: begin
          // hold one event back so the final one can carry last_result
          if (!have_pend || out_free) begin
            res       <= ev;
            have_pend <= 1'b1;
            n_res     <= n_res + lhfm_pkg::RES_CNT_W'(1);
            if (n_res == lhfm_pkg::RES_CNT_W'(lhfm_pkg::MAX_RESULTS - 1) || scan_last) begin
              state <= S_FIN;
            end else begin
              scan_s <= scan_s + AW'(1);
              state  <= S_CHK;
            end
          end
        end

        S_FIN: begin
          if (!have_pend) begin
            state <= S_IDLE;
          end else if (out_free) begin
            have_pend <= 1'b0;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lhfm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lhfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/lhfm_checker.sv =====
// Port-level checks for the link health / failover monitor, with its bind.
// Depends on lhfm_pkg; attaches to link_health_failover_monitor.
`default_nettype none

module lhfm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input lhfm_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_report_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == lhfm_pkg::KIND_REPORT |->
      out_data.last_result && !out_data.backup_found && out_data.backup_slot == 3'd0)
    else $error("malformed status report");

  a_event_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == lhfm_pkg::KIND_EVENT |->
      out_data.link_status == lhfm_pkg::ST_LOST &&
      (out_data.backup_found || out_data.backup_slot == 3'd0))
    else $error("malformed failover event");

endmodule

bind link_health_failover_monitor lhfm_checker u_lhfm_checker (.*);

`default_nettype wire
